// ===== sv/dtti_pkg.sv =====
package dtti_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] reg_addr;
    logic [7:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_flag;
  } out_word_t;

  // read map
  localparam logic [4:0] RD_PORT_A   = 5'h00;
  localparam logic [4:0] RD_PORT_B   = 5'h01;
  localparam logic [4:0] RD_CNT_A_LO = 5'h02;
  localparam logic [4:0] RD_CNT_A_HI = 5'h03;
  localparam logic [4:0] RD_CNT_B_LO = 5'h04;
  localparam logic [4:0] RD_CNT_B_HI = 5'h05;
  localparam logic [4:0] RD_TOD_0    = 5'h06;
  localparam logic [4:0] RD_TOD_1    = 5'h07;
  localparam logic [4:0] RD_TOD_2    = 5'h08;
  localparam logic [4:0] RD_TOD_3    = 5'h09;
  localparam logic [4:0] RD_STATUS   = 5'h0A;
  localparam logic [4:0] RD_CTRL_A   = 5'h0B;
  localparam logic [4:0] RD_CTRL_B   = 5'h0C;
  localparam logic [4:0] RD_SERIAL   = 5'h0D;
  localparam logic [4:0] RD_DIR_A    = 5'h0E;
  localparam logic [4:0] RD_DIR_B    = 5'h0F;

  // write map
  localparam logic [4:0] WR_DIR_A    = 5'h00;
  localparam logic [4:0] WR_PORT_A   = 5'h01;
  localparam logic [4:0] WR_REL_A_LO = 5'h02;
  localparam logic [4:0] WR_REL_A_HI = 5'h03;
  localparam logic [4:0] WR_REL_B_LO = 5'h04;
  localparam logic [4:0] WR_REL_B_HI = 5'h05;
  localparam logic [4:0] WR_HOURS    = 5'h08;
  localparam logic [4:0] WR_MINUTES  = 5'h09;
  localparam logic [4:0] WR_SECONDS  = 5'h0A;
  localparam logic [4:0] WR_TENTHS   = 5'h0B;
  localparam logic [4:0] WR_MASK     = 5'h0C;
  localparam logic [4:0] WR_ACK      = 5'h0D;
  localparam logic [4:0] WR_CTRL_A   = 5'h0E;
  localparam logic [4:0] WR_CTRL_B   = 5'h0F;
  localparam logic [4:0] WR_DIR_B    = 5'h10;
  localparam logic [4:0] WR_PORT_B   = 5'h11;
  localparam logic [4:0] WR_SERIAL   = 5'h12;

  // control register bits
  localparam int CTRL_RUN     = 0;
  localparam int CTRL_ONESHOT = 3;
  localparam int CTRL_LOAD    = 4;

  localparam logic [1:0] DELAY_A = 2'd1;
  localparam logic [1:0] DELAY_B = 2'd2;

  // status bits
  localparam logic [7:0] FLAG_TA      = 8'h01;
  localparam logic [7:0] FLAG_TB      = 8'h02;
  localparam logic [7:0] FLAG_ALARM   = 8'h04;
  localparam logic [7:0] FLAG_SUMMARY = 8'h80;

  localparam logic [7:0] HOURS_MASK   = 8'h9F;
  localparam logic [7:0] UNMAPPED_RD  = 8'hFF;

  // time-of-day wrap limits
  localparam logic [4:0] TENTHS_LIM = 5'd10;
  localparam logic [7:0] SEC_LIM    = 8'd60;
  localparam logic [7:0] MIN_LIM    = 8'd60;
  localparam logic [8:0] HOURS_LIM  = 9'd24;

  typedef struct packed {
    logic       tick;
    logic       wr_ctrl;
    logic       wr_lo;
    logic       wr_hi;
    logic [7:0] data;
  } timer_ctl_t;

  typedef struct packed {
    logic [15:0] count;
    logic [7:0]  ctrl;
  } timer_view_t;

  typedef struct packed {
    logic       tick;
    logic       wr_hours;
    logic       wr_minutes;
    logic       wr_seconds;
    logic       wr_tenths;
    logic [7:0] data;
  } tod_ctl_t;

  typedef struct packed {
    logic [3:0] tenths;
    logic [6:0] seconds;
    logic [6:0] minutes;
    logic [7:0] hours;
  } tod_view_t;

endpackage

// ===== sv/dtti_timer.sv =====
module dtti_timer
  import dtti_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  timer_ctl_t  ctl_i,
  input  logic [1:0]  start_delay_i,
  output timer_view_t view_o,
  output logic        flag_o
);

  logic [7:0]  ctrl_q, ctrl_d;
  logic [15:0] count_q, count_d;
  logic [15:0] reload_q, reload_d;
  logic [1:0]  wait_q, wait_d;
  logic [1:0]  wait_dec;
  logic [15:0] cnt_ld;

  always_comb begin
    ctrl_d   = ctrl_q;
    count_d  = count_q;
    reload_d = reload_q;
    wait_d   = wait_q;
    wait_dec = wait_q;
    cnt_ld   = count_q;
    flag_o   = 1'b0;

    if (ctl_i.tick) begin
      if (wait_q != 2'd0) begin
        wait_dec = wait_q - 2'd1;
        // start wait expiring with run set: load, then count this tick
        if (wait_dec == 2'd0 && ctrl_q[CTRL_RUN]) begin
          cnt_ld = reload_q;
        end
      end
      wait_d  = wait_dec;
      count_d = cnt_ld;
      if (ctrl_q[CTRL_RUN] && wait_dec == 2'd0) begin
        if (cnt_ld == 16'd0) begin
          count_d = reload_q;
          flag_o  = 1'b1;
          if (ctrl_q[CTRL_ONESHOT]) begin
            ctrl_d[CTRL_RUN] = 1'b0;
          end
        end else begin
          count_d = cnt_ld - 16'd1;
        end
      end
    end

    if (ctl_i.wr_lo) begin
      reload_d[7:0] = ctl_i.data;
    end
    if (ctl_i.wr_hi) begin
      reload_d[15:8] = ctl_i.data;
    end

    if (ctl_i.wr_ctrl) begin
      ctrl_d = ctl_i.data;
      if (ctl_i.data[CTRL_LOAD]) begin
        count_d = reload_q;
        wait_d  = start_delay_i;
      end
      if (ctl_i.data[CTRL_RUN] && wait_d == 2'd0) begin
        wait_d = start_delay_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q   <= '0;
      count_q  <= '0;
      reload_q <= '0;
      wait_q   <= '0;
    end else begin
      ctrl_q   <= ctrl_d;
      count_q  <= count_d;
      reload_q <= reload_d;
      wait_q   <= wait_d;
    end
  end

  assign view_o.count = count_q;
  assign view_o.ctrl  = ctrl_q;

endmodule

// ===== sv/dtti_tod.sv =====
module dtti_tod
  import dtti_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tod_ctl_t  ctl_i,
  output tod_view_t view_o,
  output logic      alarm_o
);

  tod_view_t clk_q, clk_d;
  tod_view_t alm_q, alm_d;
  logic      running_q, running_d;
  logic [4:0] nt;
  logic [7:0] ns;
  logic [7:0] nm;
  logic [8:0] nh;

  always_comb begin
    clk_d     = clk_q;
    alm_d     = alm_q;
    running_d = running_q;
    alarm_o   = 1'b0;
    nt = {1'b0, clk_q.tenths} + 5'd1;
    ns = {1'b0, clk_q.seconds} + 8'd1;
    nm = {1'b0, clk_q.minutes} + 8'd1;
    nh = {1'b0, clk_q.hours} + 9'd1;

    if (ctl_i.tick && running_q) begin
      // ripple carry: each field wraps at or above its limit
      if (nt >= TENTHS_LIM) begin
        nt = '0;
        if (ns >= SEC_LIM) begin
          ns = '0;
          if (nm >= MIN_LIM) begin
            nm = '0;
            if (nh >= HOURS_LIM) begin
              nh = '0;
            end
            clk_d.hours = nh[7:0];
          end
          clk_d.minutes = nm[6:0];
        end
        clk_d.seconds = ns[6:0];
      end
      clk_d.tenths = nt[3:0];
      alarm_o = (clk_d == alm_q);
    end

    if (ctl_i.wr_hours) begin
      clk_d.hours = ctl_i.data & HOURS_MASK;
      if (!ctl_i.data[7]) begin
        running_d = 1'b0;
      end
    end
    if (ctl_i.wr_minutes) begin
      clk_d.minutes = ctl_i.data[6:0];
    end
    if (ctl_i.wr_seconds) begin
      clk_d.seconds = ctl_i.data[6:0];
    end
    if (ctl_i.wr_tenths) begin
      // tenths write also arms the alarm with the full clock value
      clk_d.tenths = ctl_i.data[3:0];
      alm_d        = clk_d;
      if (ctl_i.data[7]) begin
        running_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q     <= '0;
      alm_q     <= '0;
      running_q <= 1'b0;
    end else begin
      clk_q     <= clk_d;
      alm_q     <= alm_d;
      running_q <= running_d;
    end
  end

  assign view_o = clk_q;

endmodule

// ===== sv/dual_timer_tod_interrupt_unit_core.sv =====
// Channel  Direction  Word        Handshake
// in       input      in_word_i   in_valid_i  / in_stall_o
// out      output     out_word_o  out_valid_o / out_stall_i
//
// One word per cycle sustained while out_stall_i is low; each word passes through the
// input register, then the result register, before its result word shows on out_word_o.
// All state updates happen in the cycle a word moves from the input register
// to the result register, so the next word always sees the updated state.
// Reset (rst_ni low, asynchronous) clears all state and the valid bits of both stages.
// A stalled result holds the result register; the input register still
// takes one more word, after which in_stall_o rises.
module dual_timer_tod_interrupt_unit_core
  import dtti_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  // input stage
  logic      in_vld_q;
  in_word_t  in_q;
  // result stage
  logic      out_vld_q;
  out_word_t out_q, out_d;

  logic fire;
  logic in_take;
  action_e act;
  logic is_tick, is_read, is_write;

  // plain byte registers
  logic [7:0] port_a_q, port_a_d;
  logic [7:0] port_b_q, port_b_d;
  logic [7:0] dir_a_q, dir_a_d;
  logic [7:0] dir_b_q, dir_b_d;
  logic [7:0] serial_q, serial_d;

  // interrupt status
  logic [7:0] status_q, status_d;
  logic       due_q, due_d;
  logic       irq_q, irq_d;
  logic [7:0] status_acked;

  timer_ctl_t  ta_ctl, tb_ctl;
  timer_view_t ta_view, tb_view;
  logic        ta_flag, tb_flag;
  tod_ctl_t    tod_ctl;
  tod_view_t   tod_view;
  logic        alarm_flag;
  logic        any_flag;

  logic [7:0] rd_byte;

  // the result register frees when empty or taken this cycle
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    act = ACT_TICK;
    is_tick = 1'b0;
    is_read = 1'b0;
    is_write = 1'b0;
    case (in_q.action)
      ACT_TICK: begin
        act = ACT_TICK;
        is_tick = fire;
      end
      ACT_READ: begin
        act = ACT_READ;
        is_read = fire;
      end
      ACT_WRITE: begin
        act = ACT_WRITE;
        is_write = fire;
      end
      default: begin
        // unused action code: no effect
        act = ACT_TICK;
      end
    endcase
  end

  // submodule strobes
  always_comb begin
    ta_ctl.tick    = is_tick;
    ta_ctl.wr_ctrl = is_write && in_q.reg_addr == WR_CTRL_A;
    ta_ctl.wr_lo   = is_write && in_q.reg_addr == WR_REL_A_LO;
    ta_ctl.wr_hi   = is_write && in_q.reg_addr == WR_REL_A_HI;
    ta_ctl.data    = in_q.write_data;

    tb_ctl.tick    = is_tick;
    tb_ctl.wr_ctrl = is_write && in_q.reg_addr == WR_CTRL_B;
    tb_ctl.wr_lo   = is_write && in_q.reg_addr == WR_REL_B_LO;
    tb_ctl.wr_hi   = is_write && in_q.reg_addr == WR_REL_B_HI;
    tb_ctl.data    = in_q.write_data;

    tod_ctl.tick       = is_tick;
    tod_ctl.wr_hours   = is_write && in_q.reg_addr == WR_HOURS;
    tod_ctl.wr_minutes = is_write && in_q.reg_addr == WR_MINUTES;
    tod_ctl.wr_seconds = is_write && in_q.reg_addr == WR_SECONDS;
    tod_ctl.wr_tenths  = is_write && in_q.reg_addr == WR_TENTHS;
    tod_ctl.data       = in_q.write_data;
  end

  dtti_timer u_timer_a (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ta_ctl),
    .start_delay_i (DELAY_A),
    .view_o        (ta_view),
    .flag_o        (ta_flag)
  );

  dtti_timer u_timer_b (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (tb_ctl),
    .start_delay_i (DELAY_B),
    .view_o        (tb_view),
    .flag_o        (tb_flag)
  );

  dtti_tod u_tod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (tod_ctl),
    .view_o  (tod_view),
    .alarm_o (alarm_flag)
  );

  assign any_flag     = ta_flag || tb_flag || alarm_flag;
  assign status_acked = status_q & ~in_q.write_data;

  // status, byte registers
  always_comb begin
    status_d = status_q;
    due_d    = due_q;
    irq_d    = irq_q;
    port_a_d = port_a_q;
    port_b_d = port_b_q;
    dir_a_d  = dir_a_q;
    dir_b_d  = dir_b_q;
    serial_d = serial_q;

    if (is_tick) begin
      // summary bit lands one tick after a flag; irq only for this tick's flags
      if (due_q) begin
        status_d = status_d | FLAG_SUMMARY;
      end
      if (ta_flag) begin
        status_d = status_d | FLAG_TA;
      end
      if (tb_flag) begin
        status_d = status_d | FLAG_TB;
      end
      if (alarm_flag) begin
        status_d = status_d | FLAG_ALARM;
      end
      due_d = any_flag;
      irq_d = any_flag;
    end

    if (is_write) begin
      case (in_q.reg_addr)
        WR_DIR_A:  dir_a_d  = in_q.write_data;
        WR_PORT_A: port_a_d = in_q.write_data;
        WR_DIR_B:  dir_b_d  = in_q.write_data;
        WR_PORT_B: port_b_d = in_q.write_data;
        WR_SERIAL: serial_d = in_q.write_data;
        WR_ACK: begin
          status_d = status_acked;
          if (status_acked != status_q) begin
            irq_d = 1'b0;
          end
        end
        // mask writes are taken and dropped: nothing reads the mask
        default: begin
        end
      endcase
    end
  end

  // register read mux
  always_comb begin
    case (in_q.reg_addr)
      RD_PORT_A:   rd_byte = port_a_q;
      RD_PORT_B:   rd_byte = port_b_q;
      RD_CNT_A_LO: rd_byte = ta_view.count[7:0];
      RD_CNT_A_HI: rd_byte = ta_view.count[15:8];
      RD_CNT_B_LO: rd_byte = tb_view.count[7:0];
      RD_CNT_B_HI: rd_byte = tb_view.count[15:8];
      RD_TOD_0:    rd_byte = {tod_view.seconds[3:0], tod_view.tenths};
      RD_TOD_1:    rd_byte = {tod_view.minutes[3:0] | {1'b0, tod_view.seconds[6:4]}, 4'h0};
      RD_TOD_2:    rd_byte = {tod_view.hours[3:0] | {1'b0, tod_view.minutes[6:4]}, 4'h0};
      RD_TOD_3:    rd_byte = {tod_view.hours[7], 7'h00};
      RD_STATUS:   rd_byte = status_q;
      RD_CTRL_A:   rd_byte = ta_view.ctrl;
      RD_CTRL_B:   rd_byte = tb_view.ctrl;
      RD_SERIAL:   rd_byte = serial_q;
      RD_DIR_A:    rd_byte = dir_a_q;
      RD_DIR_B:    rd_byte = dir_b_q;
      default:     rd_byte = UNMAPPED_RD;
    endcase
  end

  always_comb begin
    out_d.read_data = (is_read && act == ACT_READ) ? rd_byte : 8'h00;
    out_d.irq_flag  = irq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      port_a_q  <= '0;
      port_b_q  <= '0;
      dir_a_q   <= '0;
      dir_b_q   <= '0;
      serial_q  <= '0;
      status_q  <= '0;
      due_q     <= 1'b0;
      irq_q     <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      port_a_q <= port_a_d;
      port_b_q <= port_b_d;
      dir_a_q  <= dir_a_d;
      dir_b_q  <= dir_b_d;
      serial_q <= serial_d;
      status_q <= status_d;
      due_q    <= due_d;
      irq_q    <= irq_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

// ===== sv/dtti_checker.sv =====
module dtti_checker
  import dtti_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed under stall");

  // input only backs up when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // an accepted word reaches the result register when the output moves
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted word did not produce a result");

  // no stall while idle
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

endmodule

bind dual_timer_tod_interrupt_unit_core dtti_checker u_dtti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
